[sv/satl_pkg.sv]
package satl_pkg;

   localparam int ADDR_W   = 48;
   localparam int TAG_W    = 48;
   localparam int STAMP_W  = 32;
   localparam int LFSR_W   = 16;
   localparam int POLICY_W = 2;
   localparam int OFFS_W   = 4;
   localparam int CSR_W    = 4;
   localparam int KIND_W   = 2;
   localparam int WAYF_W   = 2;

   localparam int DEF_SETS      = 256;
   localparam int DEF_WAYS      = 4;
   localparam int DEF_ADDR_BITS = 48;

   localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
   localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_RAND = 2'd2;

   localparam logic [KIND_W-1:0] FK_HIT   = 2'd0;
   localparam logic [KIND_W-1:0] FK_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] FK_EVICT = 2'd2;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   localparam logic [POLICY_W-1:0] POLICY_RST = POL_LRU;
   localparam logic [OFFS_W-1:0]   OFFS_RST   = 4'd6;
   localparam logic [LFSR_W-1:0]   LFSR_SEED  = 16'hACE1;
   localparam logic [LFSR_W-1:0]   LFSR_TAPS  = 16'hB400;

   typedef struct packed {
      logic               valid;
      logic               dirty;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic rd_req;
      logic div_step;
      logic rd_rem;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
   } status_type;

   function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
      logic [LFSR_W-1:0] n;
      n = s >> 1;
      if (s[0]) begin
         n = n ^ LFSR_TAPS;
      end
      return n;
   endfunction

endpackage

[sv/satl_if.sv]
interface satl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [satl_pkg::ADDR_W-1:0] addr;

   modport source (output valid, output req_type, output addr, input ready);
   modport sink (input valid, input req_type, input addr, output ready);
endinterface

interface satl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [satl_pkg::WAYF_W-1:0] way;
   logic [satl_pkg::KIND_W-1:0] fill_kind;
   logic [satl_pkg::TAG_W-1:0]  victim_tag;
   logic                        writeback;

   modport source (output valid, output hit, output way, output fill_kind,
                   output victim_tag, output writeback, input ready);
   modport sink (input valid, input hit, input way, input fill_kind,
                 input victim_tag, input writeback, output ready);
endinterface

[sv/satl_ctrl.sv]
module satl_ctrl #(
   parameter int SETS = satl_pkg::DEF_SETS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  satl_pkg::status_type  status,
   output satl_pkg::cmd_type     cmd
);
   import satl_pkg::*;

   localparam bit  SETS_POW2 = (SETS & (SETS - 1)) == 0;
   // fold, reciprocal multiply, remainder
   localparam int  DIV_STEPS = 3;
   localparam int  CNT_W     = 2;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) state_in = SETS_POW2 ? ST_EXEC : ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = accept;
            cmd.rd_req = accept && SETS_POW2;
         end
         ST_DIV:  cmd.div_step = 1'b1;
         ST_READ: cmd.rd_rem = 1'b1;
         ST_EXEC: cmd.exec = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

[sv/satl_dp.sv]
module satl_dp #(
   parameter int SETS      = satl_pkg::DEF_SETS,
   parameter int WAYS      = satl_pkg::DEF_WAYS,
   parameter int ADDR_BITS = satl_pkg::DEF_ADDR_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  satl_pkg::cmd_type             cmd,
   output satl_pkg::status_type          status,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [satl_pkg::CSR_W-1:0]    csr_wr_data,
   input  logic                          req_type,
   input  logic [satl_pkg::ADDR_W-1:0]   req_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [satl_pkg::WAYF_W-1:0]   rsp_way,
   output logic [satl_pkg::KIND_W-1:0]   rsp_fill_kind,
   output logic [satl_pkg::TAG_W-1:0]    rsp_victim_tag,
   output logic                          rsp_writeback
);
   import satl_pkg::*;

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LVL   = WAY_W;
   localparam int NP    = 1 << LVL;
   localparam logic [ADDR_W-1:0] AMASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));
   localparam logic [32:0] RMUL =
      33'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

   // byte weights modulo SETS and the reciprocal for the folded value
   localparam int FOLD_W = 27;
   localparam int RSH    = FOLD_W + SET_W;
   localparam logic [15:0] CW1 = 16'((64'd1 << 8)  % 64'(SETS));
   localparam logic [15:0] CW2 = 16'((64'd1 << 16) % 64'(SETS));
   localparam logic [15:0] CW3 = 16'((64'd1 << 24) % 64'(SETS));
   localparam logic [15:0] CW4 = 16'((64'd1 << 32) % 64'(SETS));
   localparam logic [15:0] CW5 = 16'((64'd1 << 40) % 64'(SETS));
   localparam logic [FOLD_W+1:0] FMUL =
      (FOLD_W + 2)'(((64'd1 << RSH) + 64'(SETS) - 64'd1) / 64'(SETS));

   // configuration
   logic [POLICY_W-1:0] policy_ff;
   logic [OFFS_W-1:0]   offs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RST;
         offs_ff   <= OFFS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLICY: policy_ff <= csr_wr_data[POLICY_W-1:0];
            CSR_OFFSET: offs_ff   <= csr_wr_data[OFFS_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture and set index
   logic [ADDR_W-1:0]     laddr_c, laddr_ff;
   logic [SET_W-1:0]      set_c, rem_ff, set_ff, rd_addr;
   logic                  wr_ff;
   logic [23:0]           part1, part2, part3, part4, part5;
   logic [FOLD_W-1:0]     fold_c, fold_ff, quo_ff, qs;
   logic [2*FOLD_W+1:0]   qprod;

   assign laddr_c = (req_addr & AMASK) >> offs_ff;
   assign set_c   = (SETS == 1) ? '0 : laddr_c[SET_W-1:0];
   assign rd_addr = cmd.rd_req ? set_c : rem_ff;

   // fold bytes by their weights, then exact reciprocal quotient
   assign part1  = laddr_ff[15:8]  * CW1;
   assign part2  = laddr_ff[23:16] * CW2;
   assign part3  = laddr_ff[31:24] * CW3;
   assign part4  = laddr_ff[39:32] * CW4;
   assign part5  = laddr_ff[47:40] * CW5;
   assign fold_c = FOLD_W'(laddr_ff[7:0]) + FOLD_W'(part1) + FOLD_W'(part2)
                 + FOLD_W'(part3) + FOLD_W'(part4) + FOLD_W'(part5);
   assign qprod  = fold_ff * FMUL;
   assign qs     = quo_ff * FOLD_W'(SETS);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         laddr_ff <= laddr_c;
         wr_ff    <= req_type;
      end else if (cmd.div_step) begin
         fold_ff <= fold_c;
         quo_ff  <= FOLD_W'(qprod >> RSH);
         rem_ff  <= SET_W'(fold_ff - qs);
      end
      if (cmd.rd_req || cmd.rd_rem) begin
         set_ff <= rd_addr;
      end
   end

   // set memory, one row holds all ways
   line_type [WAYS-1:0] mem_q [SETS];
   line_type [WAYS-1:0] row_q, row_new;
   logic [SET_W-1:0]    clr_ff;

   assign status.clr_last = clr_ff == SET_W'(SETS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_req || cmd.rd_rem) begin
         row_q <= mem_q[rd_addr];
      end
      if (cmd.clr_step) begin
         mem_q[clr_ff] <= '0;
      end else if (cmd.exec) begin
         mem_q[set_ff] <= row_new;
      end
   end

   // random way: reciprocal multiply registered, remainder fixed in exec
   logic [LFSR_W-1:0] lfsr_ff, nxt_ff, q_ff, rnd_r;
   logic [48:0]       rprod;
   logic [WAY_W-1:0]  rnd_way;

   assign rprod = 49'(lfsr_next(lfsr_ff)) * 49'(RMUL);

   always_ff @(posedge clock) begin
      nxt_ff <= lfsr_next(lfsr_ff);
      q_ff   <= rprod[47:32];
   end

   always_comb begin
      rnd_r = nxt_ff - LFSR_W'(q_ff * WAYS);
      if (rnd_r >= LFSR_W'(WAYS)) begin
         rnd_r = rnd_r - LFSR_W'(WAYS);
      end
      rnd_way = rnd_r[WAY_W-1:0];
   end

   // lookup
   logic [STAMP_W-1:0] tick_ff, tick_n;
   logic [STAMP_W-1:0] ts [LVL+1][NP];
   logic [WAY_W-1:0]   ti [LVL+1][NP];
   logic               found, freefound, evict;
   logic [WAY_W-1:0]   hit_way, free_way, sel;
   logic [KIND_W-1:0]  kind;

   assign tick_n = tick_ff + 1'b1;

   always_comb begin
      found    = 1'b0;
      hit_way  = '0;
      freefound = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_q[w].valid && row_q[w].tag == laddr_ff) begin
            found   = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!row_q[w].valid) begin
            freefound = 1'b1;
            free_way  = WAY_W'(w);
         end
      end
   end

   // oldest stamp tree, left wins ties
   always_comb begin
      ts = '{default: '0};
      ti = '{default: '0};
      for (int i = 0; i < NP; i++) begin
         if (i < WAYS) begin
            ts[0][i] = row_q[(i < WAYS) ? i : 0].stamp;
         end else begin
            ts[0][i] = '1;
         end
         ti[0][i] = WAY_W'(i);
      end
      for (int lv = 0; lv < LVL; lv++) begin
         for (int j = 0; j < NP / 2; j++) begin
            if (ts[lv][2*j+1] < ts[lv][2*j]) begin
               ts[lv+1][j] = ts[lv][2*j+1];
               ti[lv+1][j] = ti[lv][2*j+1];
            end else begin
               ts[lv+1][j] = ts[lv][2*j];
               ti[lv+1][j] = ti[lv][2*j];
            end
         end
      end
   end

   always_comb begin
      evict   = 1'b0;
      row_new = row_q;
      if (found) begin
         sel  = hit_way;
         kind = FK_HIT;
         if (wr_ff) row_new[sel].dirty = 1'b1;
         if (policy_ff != POL_FIFO) row_new[sel].stamp = tick_n;
      end else begin
         if (freefound) begin
            sel  = free_way;
            kind = FK_FREE;
         end else begin
            evict = 1'b1;
            kind  = FK_EVICT;
            sel   = (policy_ff == POL_RAND) ? rnd_way : ti[LVL][0];
         end
         row_new[sel].valid = 1'b1;
         row_new[sel].dirty = wr_ff;
         row_new[sel].tag   = laddr_ff;
         row_new[sel].stamp = tick_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         lfsr_ff <= LFSR_SEED;
      end else if (cmd.exec) begin
         tick_ff <= tick_n;
         if (evict && policy_ff == POL_RAND) lfsr_ff <= nxt_ff;
      end
   end

   // result register
   logic rsp_valid_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_hit        <= found;
         rsp_way        <= WAYF_W'(sel);
         rsp_fill_kind  <= kind;
         rsp_victim_tag <= evict ? row_q[sel].tag : '0;
         rsp_writeback  <= evict && row_q[sel].dirty && row_q[sel].valid;
      end
   end

endmodule

[sv/set_assoc_cache_tag_lookup.sv]
// Tag lookup for a write-back, write-allocate set-associative cache.
// req_bus carries one beat per access (req_type 0 read, 1 write, byte addr).
// rsp_bus returns one beat per request: hit, way, fill_kind (hit, free fill,
// eviction), victim_tag and writeback for a dirty evicted line.
// csr_* writes policy (index 0) and line offset bits (index 1); the user is
// to write them only while the block is idle, which the block itself does
// not enforce; writes take effect on the next request.
// With SETS a power of two a request does a set-row read of the tag memory as
// it is taken, then a compute-and-write step; otherwise a byte fold, a
// reciprocal multiply and a remainder give the set index before the read.
// A new request is taken only once the previous one has been computed and written.
// After reset a clearing pass zeroes the tag memory one set per cycle, with
// req ready low; csr writes are taken meanwhile.
// A finished beat waits in the result register while the next request is
// taken; if the receiver stalls, the following request holds in its final
// cycle until the register frees.
module set_assoc_cache_tag_lookup #(
   parameter int SETS      = satl_pkg::DEF_SETS,
   parameter int WAYS      = satl_pkg::DEF_WAYS,
   parameter int ADDR_BITS = satl_pkg::DEF_ADDR_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   satl_req_if.sink                   req_bus,
   satl_rsp_if.source                 rsp_bus,
   input  logic                       csr_wr_en,
   input  logic                       csr_index,
   input  logic [satl_pkg::CSR_W-1:0] csr_wr_data
);
   import satl_pkg::*;

   cmd_type    cmd;
   status_type status;

   satl_ctrl #(.SETS(SETS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   satl_dp #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_type       (req_bus.req_type),
      .req_addr       (req_bus.addr),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_hit        (rsp_bus.hit),
      .rsp_way        (rsp_bus.way),
      .rsp_fill_kind  (rsp_bus.fill_kind),
      .rsp_victim_tag (rsp_bus.victim_tag),
      .rsp_writeback  (rsp_bus.writeback)
   );

   a_exec_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_bus.valid)
      else $error("result beat missing after exec");

   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.hit == (rsp_bus.fill_kind == FK_HIT)))
      else $error("hit and fill_kind disagree");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.fill_kind != FK_EVICT)
         |-> (rsp_bus.victim_tag == '0 && !rsp_bus.writeback))
      else $error("victim reported without eviction");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept) |=> !req_bus.ready)
      else $error("request taken while previous one in flight");

endmodule

[sim/set_assoc_cache_tag_lookup_tb.sv]
module set_assoc_cache_tag_lookup_tb;
   import satl_pkg::*;

   localparam int NSETS = DEF_SETS;
   localparam int NWAYS = DEF_WAYS;

   typedef struct packed {
      logic              hit;
      logic [WAYF_W-1:0] way;
      logic [KIND_W-1:0] fill_kind;
      logic [TAG_W-1:0]  victim_tag;
      logic              writeback;
   } lookup_type;

   class tag_scoreboard;
      logic               valid_q [NSETS*NWAYS];
      logic               dirty_q [NSETS*NWAYS];
      logic [TAG_W-1:0]   tag_q   [NSETS*NWAYS];
      logic [STAMP_W-1:0] stamp_q [NSETS*NWAYS];
      logic [STAMP_W-1:0] tick;
      logic [LFSR_W-1:0]  lfsr;
      logic [POLICY_W-1:0] policy;
      logic [OFFS_W-1:0]  offset;
      lookup_type         pending [$];
      int                 errors;

      function new();
         for (int i = 0; i < NSETS*NWAYS; i++) begin
            valid_q[i] = 0;
            dirty_q[i] = 0;
            tag_q[i]   = '0;
            stamp_q[i] = '0;
         end
         tick   = '0;
         lfsr   = LFSR_SEED;
         policy = POLICY_RST;
         offset = OFFS_RST;
         errors = 0;
      endfunction

      function void note_access(logic is_write, logic [ADDR_W-1:0] addr);
         logic [TAG_W-1:0] laddr;
         int base, sel, w;
         bit found, freef;
         lookup_type r;
         logic [STAMP_W-1:0] best;
         laddr = addr >> offset;
         base = int'(laddr % NSETS) * NWAYS;
         sel = 0;
         found = 0;
         freef = 0;
         r = '0;
         tick = tick + 1;
         for (w = 0; w < NWAYS; w++)
            if (!found && valid_q[base+w] && tag_q[base+w] == laddr) begin
               sel = w;
               found = 1;
            end
         if (found) begin
            r.fill_kind = FK_HIT;
            if (is_write) dirty_q[base+sel] = 1;
            if (policy != POL_FIFO) stamp_q[base+sel] = tick;
         end else begin
            for (w = 0; w < NWAYS; w++)
               if (!freef && !valid_q[base+w]) begin
                  sel = w;
                  freef = 1;
               end
            if (freef) begin
               r.fill_kind = FK_FREE;
            end else begin
               r.fill_kind = FK_EVICT;
               if (policy == POL_RAND) begin
                  lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
                  sel = int'(lfsr % NWAYS);
               end else begin
                  best = stamp_q[base];
                  for (w = 1; w < NWAYS; w++)
                     if (stamp_q[base+w] < best) begin
                        best = stamp_q[base+w];
                        sel = w;
                     end
               end
               r.victim_tag = tag_q[base+sel];
               r.writeback  = dirty_q[base+sel];
            end
            valid_q[base+sel] = 1;
            dirty_q[base+sel] = is_write;
            tag_q[base+sel]   = laddr;
            stamp_q[base+sel] = tick;
         end
         r.hit = found;
         r.way = sel[WAYF_W-1:0];
         pending.push_back(r);
      endfunction

      function void check_lookup(lookup_type got);
         lookup_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %p", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.hit !== exp.hit)
            $display("%0t: hit exp %0d got %0d", $time, exp.hit, got.hit);
         if (got.way !== exp.way)
            $display("%0t: way exp %0d got %0d", $time, exp.way, got.way);
         if (got.fill_kind !== exp.fill_kind)
            $display("%0t: fill_kind exp %0d got %0d", $time, exp.fill_kind,
                     got.fill_kind);
         if (got.victim_tag !== exp.victim_tag)
            $display("%0t: victim_tag exp %h got %h", $time, exp.victim_tag,
                     got.victim_tag);
         if (got.writeback !== exp.writeback)
            $display("%0t: writeback exp %0d got %0d", $time, exp.writeback,
                     got.writeback);
         if (got !== exp) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic csr_index = CSR_POLICY;
   logic [CSR_W-1:0] csr_wr_data = '0;
   int send_idle = 0;
   int recv_stall = 0;
   tag_scoreboard sb;

   satl_req_if req_bus();
   satl_rsp_if rsp_bus();

   set_assoc_cache_tag_lookup u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.req_type = 0;
      req_bus.addr = '0;
      rsp_bus.ready = 0;
   end

   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready)
         sb.check_lookup({rsp_bus.hit, rsp_bus.way, rsp_bus.fill_kind,
                          rsp_bus.victim_tag, rsp_bus.writeback});
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   // valid stays up after a beat so back-to-back items see a single drive
   task automatic send_access(logic is_write, logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 0;
         @(posedge clock);
      end
      req_bus.valid    <= 1;
      req_bus.req_type <= is_write;
      req_bus.addr     <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_access(is_write, addr);
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] val);
      drain();
      csr_wr_en   <= 1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      if (idx == CSR_POLICY) sb.policy = val[POLICY_W-1:0];
      else sb.offset = val;
   endtask

   // addresses drawn from a small pool of tags per set so hits and evictions recur
   function automatic logic [ADDR_W-1:0] pool_addr(int span);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'({$urandom, $urandom});
      a = (a & ~((48'd1 << (sb.offset + 8 + span)) - 1)) == 0 ? a :
          (a & ((48'd1 << (sb.offset + 8 + span)) - 1));
      if ($urandom_range(9) == 0) a = ADDR_W'({$urandom, $urandom});
      return a;
   endfunction

   task automatic random_phase(int n, int span);
      for (int i = 0; i < n; i++)
         send_access(1'($urandom_range(1)), pool_addr(span));
   endtask

   initial begin
      int span;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: free fills, hits, dirty eviction, field extremes
      for (int k = 0; k < 5; k++) send_access(1'b1, 48'(k) << 14);
      send_access(1'b0, 48'h0);
      send_access(1'b1, 48'h4000);
      for (int k = 0; k < 5; k++) send_access(1'b0, 48'(k+5) << 14);
      send_access(1'b0, 48'hFFFF_FFFF_FFFF);
      send_access(1'b1, 48'hFFFF_FFFF_FFFF);
      send_access(1'b0, 48'h8000_0000_0000);
      send_access(1'b1, 48'h3F);
      // policy 3 acts like lru, out-of-range offset
      write_csr(CSR_POLICY, 4'd3);
      write_csr(CSR_OFFSET, 4'd15);
      for (int k = 0; k < 6; k++) send_access(k[0], ADDR_W'({$urandom, $urandom}));
      write_csr(CSR_OFFSET, 4'd0);
      for (int k = 0; k < 6; k++) send_access(1'b1, 48'(k) << 8);
      // random phases over policies, offsets, idling mixes
      for (int ph = 0; ph < 12; ph++) begin
         write_csr(CSR_POLICY, 4'(ph % 3));
         write_csr(CSR_OFFSET, (ph % 4 == 3) ? 4'd12 : 4'($urandom_range(12)));
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 79; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 79; end
            default: begin send_idle = 28; recv_stall = 28; end
         endcase
         if (ph == 5) recv_stall = 0;
         span = $urandom_range(2);
         random_phase(45, span);
         drain();
         random_phase(45, span);
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
